// File: rtl/core/escape_sequence_decoder_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the escape sequence decoder
// Concurrent checks clocked on aclk, disabled while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef ESCAPE_SEQUENCE_DECODER_CORE_ASSERT_SVH
`define ESCAPE_SEQUENCE_DECODER_CORE_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define ESCD_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("escd assertion failed");

// antecedent implies consequent in the next cycle
`define ESCD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("escd assertion failed");

`endif

// File: rtl/core/escd_pkg.sv
// ----------------------------------------------------------------------------
// escd_pkg
// Shared types, codes and helpers of the escape sequence decoder.
// ----------------------------------------------------------------------------
package escd_pkg;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_DIGIT = 2'd1;
    localparam logic [1:0] ST_EARLY_END = 2'd2;

    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_QMARK  = 8'h3F;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_X      = 8'h78;
    localparam logic [7:0] CH_A      = 8'h61;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_V      = 8'h76;

    // one decoded command: one result, or a pair (data0 then data1)
    typedef struct packed {
        logic [7:0] data0;
        logic [7:0] data1;
        logic       pair;
        logic       last;
        logic [1:0] status;
    } entry_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_status_t;

    // bit 4 set: not a hex digit
    function automatic logic [4:0] hex_val(input logic [7:0] b);
        logic [4:0] v;
        v = 5'h10;
        if (b >= 8'h30 && b <= 8'h39) begin
            v = {1'b0, 4'(b - 8'h30)};
        end else if (b >= 8'h61 && b <= 8'h66) begin
            v = {1'b0, 4'(b - 8'h57)};
        end else if (b >= 8'h41 && b <= 8'h46) begin
            v = {1'b0, 4'(b - 8'h37)};
        end
        return v;
    endfunction

    function automatic logic is_octal(input logic [7:0] b);
        return b[7:3] == 5'b00110;
    endfunction

endpackage

// File: rtl/core/escd_front.sv
// ----------------------------------------------------------------------------
// escd_front
// Accepts source bytes, tracks escape state and issues decoded commands.
// ----------------------------------------------------------------------------
module escd_front (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [7:0]       s_tdata,   // [7:0] in_byte
    input  logic             s_tlast,
    input  escd_pkg::q_status_t q_stat,
    output logic             push,
    output escd_pkg::entry_t push_entry
);
    import escd_pkg::*;

    typedef enum logic [2:0] {
        MODE_PLAIN = 3'd0,
        MODE_ESC   = 3'd1,
        MODE_HEX1  = 3'd2,
        MODE_HEX2  = 3'd3,
        MODE_OCT2  = 3'd4,
        MODE_OCT3  = 3'd5,
        MODE_DROP  = 3'd6
    } mode_t;

    mode_t      mode_reg, mode_next;
    logic [7:0] acc_reg, acc_next;
    logic       accept;
    logic [4:0] hx;
    logic       oct;
    logic [2:0] od;
    entry_t     e;

    assign s_tready   = !q_stat.full;
    assign accept     = s_tvalid && s_tready;
    assign hx         = hex_val(s_tdata);
    assign oct        = is_octal(s_tdata);
    assign od         = s_tdata[2:0];
    assign push_entry = e;

    always_comb begin
        mode_next = mode_reg;
        acc_next  = acc_reg;
        push      = 1'b0;
        e         = '0;
        e.last    = s_tlast;
        e.status  = ST_OK;
        if (accept) begin
            case (mode_reg)
                MODE_ESC: begin
                    mode_next = MODE_PLAIN;
                    push      = 1'b1;
                    case (s_tdata)
                        CH_SQUOTE, CH_QMARK, CH_BSLASH: e.data0 = s_tdata;
                        CH_DQUOTE: begin
                            e.data0 = CH_BSLASH;
                            e.data1 = CH_DQUOTE;
                            e.pair  = 1'b1;
                        end
                        CH_A: e.data0 = 8'h07;
                        CH_B: e.data0 = 8'h08;
                        CH_F: e.data0 = 8'h0C;
                        CH_N: e.data0 = 8'h0A;
                        CH_R: e.data0 = 8'h0D;
                        CH_T: e.data0 = 8'h09;
                        CH_V: e.data0 = 8'h0B;
                        CH_X: begin
                            if (s_tlast) begin
                                e.status = ST_EARLY_END;
                                acc_next = '0;
                            end else begin
                                push      = 1'b0;
                                mode_next = MODE_HEX1;
                            end
                        end
                        default: begin
                            if (oct) begin
                                if (s_tlast) begin
                                    e.status = ST_EARLY_END;
                                    acc_next = '0;
                                end else begin
                                    push      = 1'b0;
                                    acc_next  = {od[1:0], 6'b0};
                                    mode_next = MODE_OCT2;
                                end
                            end else begin
                                e.data0 = CH_BSLASH;
                                e.data1 = s_tdata;
                                e.pair  = 1'b1;
                            end
                        end
                    endcase
                end
                MODE_HEX1: begin
                    if (hx[4] || s_tlast) begin
                        push      = 1'b1;
                        e.status  = hx[4] ? ST_BAD_DIGIT : ST_EARLY_END;
                        e.last    = 1'b1;
                        acc_next  = '0;
                        mode_next = s_tlast ? MODE_PLAIN : MODE_DROP;
                    end else begin
                        acc_next  = {hx[3:0], 4'b0};
                        mode_next = MODE_HEX2;
                    end
                end
                MODE_HEX2: begin
                    push     = 1'b1;
                    acc_next = '0;
                    if (hx[4]) begin
                        e.status  = ST_BAD_DIGIT;
                        e.last    = 1'b1;
                        mode_next = s_tlast ? MODE_PLAIN : MODE_DROP;
                    end else begin
                        e.data0   = acc_reg + {4'b0, hx[3:0]};
                        mode_next = MODE_PLAIN;
                    end
                end
                MODE_OCT2: begin
                    if (!oct || s_tlast) begin
                        push      = 1'b1;
                        e.status  = !oct ? ST_BAD_DIGIT : ST_EARLY_END;
                        e.last    = 1'b1;
                        acc_next  = '0;
                        mode_next = s_tlast ? MODE_PLAIN : MODE_DROP;
                    end else begin
                        acc_next  = acc_reg + {2'b0, od, 3'b0};
                        mode_next = MODE_OCT3;
                    end
                end
                MODE_OCT3: begin
                    push     = 1'b1;
                    acc_next = '0;
                    if (!oct) begin
                        e.status  = ST_BAD_DIGIT;
                        e.last    = 1'b1;
                        mode_next = s_tlast ? MODE_PLAIN : MODE_DROP;
                    end else begin
                        e.data0   = acc_reg + {5'b0, od};
                        mode_next = MODE_PLAIN;
                    end
                end
                MODE_DROP: begin
                    if (s_tlast) begin
                        mode_next = MODE_PLAIN;
                        acc_next  = '0;
                    end
                end
                default: begin
                    mode_next = MODE_PLAIN;
                    e.data0   = s_tdata;
                    push      = 1'b1;
                    if (s_tdata == CH_BSLASH && !s_tlast) begin
                        push      = 1'b0;
                        mode_next = MODE_ESC;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_PLAIN;
            acc_reg  <= '0;
        end else begin
            mode_reg <= mode_next;
            acc_reg  <= acc_next;
        end
    end

endmodule

// File: rtl/core/escd_fifo.sv
// ----------------------------------------------------------------------------
// escd_fifo
// Small command queue between the decode front and the output back end.
// ----------------------------------------------------------------------------
module escd_fifo #(
    parameter int DEPTH = escd_pkg::QUEUE_DEPTH
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  escd_pkg::entry_t push_entry,
    input  logic             pop,
    output escd_pkg::entry_t head,
    output escd_pkg::q_status_t q_stat
);
    import escd_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    entry_t        slots[DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    assign q_stat.empty = (count_reg == '0);
    assign q_stat.full  = (count_reg == CW'(DEPTH));
    assign head         = slots[rd_ptr_reg];
    assign do_push      = push && !q_stat.full;
    assign do_pop       = pop && !q_stat.empty;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!do_push && do_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slots[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: rtl/core/escd_back.sv
// ----------------------------------------------------------------------------
// escd_back
// Expands queued commands into result transfers through an output register.
// ----------------------------------------------------------------------------
`include "escape_sequence_decoder_core_assert.svh"

module escd_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  escd_pkg::entry_t    head,
    input  escd_pkg::q_status_t q_stat,
    output logic                pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [7:0]          m_tdata,   // [7:0] out_byte
    output logic                m_tlast,
    output logic [1:0]          m_tuser    // [1:0] status
);
    import escd_pkg::*;

    logic       phase_reg, phase_next;
    logic       valid_reg, valid_next;
    logic [7:0] data_reg, data_next;
    logic       last_reg, last_next;
    logic [1:0] user_reg, user_next;
    logic       load;

    assign load = !q_stat.empty && (!valid_reg || m_tready);

    always_comb begin
        phase_next = phase_reg;
        valid_next = valid_reg;
        data_next  = data_reg;
        last_next  = last_reg;
        user_next  = user_reg;
        pop        = 1'b0;
        if (load) begin
            valid_next = 1'b1;
            if (head.pair && !phase_reg) begin
                data_next  = head.data0;
                last_next  = 1'b0;
                user_next  = ST_OK;
                phase_next = 1'b1;
            end else begin
                data_next  = phase_reg ? head.data1 : head.data0;
                last_next  = head.last;
                user_next  = head.status;
                phase_next = 1'b0;
                pop        = 1'b1;
            end
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= 1'b0;
            valid_reg <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            valid_reg <= valid_next;
        end
        data_reg <= data_next;
        last_reg <= last_next;
        user_reg <= user_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;
    assign m_tuser  = user_reg;

    `ESCD_ASSERT_IMPL(a_phase_on_pair, phase_reg, !q_stat.empty && head.pair)
    `ESCD_ASSERT_IMPL(a_err_closes, valid_reg && user_reg != ST_OK, last_reg && data_reg == '0)
    `ESCD_ASSERT_NEXT(a_first_half_open, load && !pop, valid_reg && !last_reg && phase_reg)

endmodule

// File: rtl/core/escape_sequence_decoder_core.sv
// ----------------------------------------------------------------------------
// escape_sequence_decoder_core
// Decoded commands pass through the command queue, then the output register.
// Throughput: one source byte per cycle unless the queue is full; one result
// per cycle at m_* unless stalled; a pair command sends two results in turn.
// The command queue (FIFO_DEPTH entries) absorbs bursts between the two sides.
// Reset (aresetn low, synchronous) empties the queue and returns to plain text.
// ----------------------------------------------------------------------------
module escape_sequence_decoder_core #(
    parameter int FIFO_DEPTH = escd_pkg::QUEUE_DEPTH
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tlast,
    output logic [1:0] m_tuser    // [1:0] status
);
    import escd_pkg::*;

    logic      push;
    logic      pop;
    entry_t    push_entry;
    entry_t    head;
    q_status_t q_stat;

    escd_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .q_stat     (q_stat),
        .push       (push),
        .push_entry (push_entry)
    );

    escd_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .q_stat     (q_stat)
    );

    escd_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (head),
        .q_stat   (q_stat),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule
